@@ design/apu_pkg.sv @@
package apu_pkg;

    localparam int BYTE_W          = 8;
    localparam int NUM_CH          = 4;
    localparam int PIX_W           = BYTE_W * NUM_CH;
    localparam int CFG_W           = 11;
    localparam int APB_DW          = 32;
    localparam int APB_AW          = 3;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int RST_IMAGE_WIDTH = 1024;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH = 1'b0;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [PIX_W-1:0]  t_pixel;

    // where the current pixel sits in the frame
    typedef struct packed {
        logic first_row;
        logic col_zero;
    } t_pos;

endpackage

@@ design/average_predictor_unfilter.sv @@
// Average-prediction inverse filter, four byte channels per pixel.
// Slave stream: one pixel word per handshake in raster order; tuser[0] marks
// the first pixel of a frame and restarts row and column. Master stream: one
// reconstructed pixel word for each word taken in, same order.
// APB port: one register, image_width at byte address 0 (row length and line
// store stride; 0 acts as 1, above MAX_WIDTH acts as MAX_WIDTH). Write it only
// while the stream is idle.
// Throughput: one pixel per cycle while the master does not stall. The only feedback is
// the left pixel, held in r_left; the line store has one write and one read port.
// Path: an accepted word passes through the input stage, then the result register,
// before it is presented on the master side.
// Reset: synchronous, active low; clears both pipeline valids, sets column 0
// and first row, left pixel zero, image_width 1024. The line store is not
// cleared: the first row never uses what it reads from it.
// Stall: when the master holds tready low, the result register holds, the
// input stage fills and then s_axis_tready drops; no word is lost.
module average_predictor_unfilter #(
    parameter int MAX_WIDTH = apu_pkg::DEF_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [apu_pkg::PIX_W-1:0]   s_axis_tdata,  // chan0_in, chan1_in, chan2_in, alpha_in
    input  logic [0:0]                  s_axis_tuser,  // frame_start
    // master stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [apu_pkg::PIX_W-1:0]   m_axis_tdata,  // chan0_out, chan1_out, chan2_out, alpha_out
    // APB config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [apu_pkg::APB_AW-1:0]  paddr,
    input  logic [apu_pkg::APB_DW-1:0]  pwdata,
    output logic [apu_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import apu_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);

    // config register
    logic [CFG_W-1:0] r_image_width;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= CFG_W'(RST_IMAGE_WIDTH);
        end else if (cfg_wr && (paddr[2] == REG_IMAGE_WIDTH)) begin
            r_image_width <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IMAGE_WIDTH) begin
            prdata = APB_DW'(r_image_width);
        end
    end

    // handshake
    logic s_accept, adv, s1_move;

    // input stage
    logic             r_s1_valid;
    t_pixel           r_s1_data;
    t_pos             r_s1_pos;
    logic [CNT_W-1:0] r_s1_col;
    logic             r_fwd;      // above pixel is the one written on load

    // result stage
    logic             r_out_valid;
    t_pixel           r_out_data;
    t_pixel           r_left;

    logic [CNT_W-1:0] cur_col;
    t_pos             cur_pos;
    t_pixel           mem_q, above, result;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && adv;
    assign s_axis_tready = !r_s1_valid || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    apu_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_frame_start (s_axis_tuser[0]),
        .i_image_width (r_image_width),
        .o_col         (cur_col),
        .o_pos         (cur_pos)
    );

    apu_lstore #(
        .DEPTH (MAX_WIDTH),
        .AW    (CNT_W)
    ) u_lstore (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_col),
        .i_wr_data (result),
        .i_rd_en   (s_accept),
        .i_rd_addr (cur_col),
        .o_rd_data (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_data <= s_axis_tdata;
            r_s1_pos  <= cur_pos;
            r_s1_col  <= cur_col;
            // very narrow rows: the pixel above is being written this edge
            r_fwd     <= s1_move && (r_s1_col == cur_col);
        end
    end

    // the forwarded pixel is the last result, which r_left holds
    assign above = r_fwd ? r_left : mem_q;

    apu_recon u_recon (
        .i_filt  (r_s1_data),
        .i_above (above),
        .i_left  (r_left),
        .i_pos   (r_s1_pos),
        .o_pixel (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_left <= result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // an accepted word always lands in the input stage
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid)
        else $error("accepted word missing from input stage");

    // a word leaving the input stage always shows up at the output
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("result register did not take the word");

    // forwarding only when the write and read columns matched
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !(s1_move && (r_s1_col == cur_col))) |=> !r_fwd)
        else $error("spurious line store bypass");

    // a held input stage keeps its word while the output is stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_data)))
        else $error("input stage changed under stall");

endmodule

@@ design/apu_lstore.sv @@
module apu_lstore #(
    parameter int DEPTH = apu_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  apu_pkg::t_pixel      i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output apu_pkg::t_pixel      o_rd_data
);
    import apu_pkg::*;

    t_pixel r_mem [DEPTH];
    t_pixel r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-first: a same-edge write is not seen here
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/apu_ctrl.sv @@
module apu_ctrl #(
    parameter int MAX_WIDTH = apu_pkg::DEF_MAX_WIDTH,
    parameter int CNT_W     = $clog2(MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_frame_start,
    input  logic [apu_pkg::CFG_W-1:0]  i_image_width,
    output logic [CNT_W-1:0]           o_col,
    output apu_pkg::t_pos              o_pos
);
    import apu_pkg::*;

    localparam int CMP_W = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;

    logic [CNT_W-1:0] r_col, n_col;
    logic             r_first, n_first;
    logic [CMP_W-1:0] cfg_ext, eff_w, col_pre_ext, nxt_col;
    logic [CNT_W-1:0] col_pre, col_cur;
    logic             first_pre, first_cur, wrap;

    always_comb begin
        cfg_ext = CMP_W'(i_image_width);
        if (cfg_ext == '0) begin
            eff_w = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = cfg_ext;
        end

        col_pre     = i_frame_start ? '0 : r_col;
        first_pre   = i_frame_start | r_first;
        col_pre_ext = CMP_W'(col_pre);
        // width lowered under the current column: start a new row
        wrap        = (col_pre_ext >= eff_w);
        col_cur     = wrap ? '0 : col_pre;
        first_cur   = wrap ? 1'b0 : first_pre;

        nxt_col = CMP_W'(col_cur) + CMP_W'(1);
        if (nxt_col >= eff_w) begin
            n_col   = '0;
            n_first = 1'b0;
        end else begin
            n_col   = nxt_col[CNT_W-1:0];
            n_first = first_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

    assign o_col           = col_cur;
    assign o_pos.first_row = first_cur;
    assign o_pos.col_zero  = (col_cur == '0);

endmodule

@@ design/apu_recon.sv @@
module apu_recon (
    input  apu_pkg::t_pixel i_filt,
    input  apu_pkg::t_pixel i_above,
    input  apu_pkg::t_pixel i_left,
    input  apu_pkg::t_pos   i_pos,
    output apu_pkg::t_pixel o_pixel
);
    import apu_pkg::*;

    always_comb begin
        t_byte             x, a, l;
        logic [BYTE_W:0]   sum;
        o_pixel = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            x   = i_filt[k*BYTE_W +: BYTE_W];
            a   = i_above[k*BYTE_W +: BYTE_W];
            l   = i_left[k*BYTE_W +: BYTE_W];
            sum = {1'b0, a} + {1'b0, l};
            // first pixel of a frame has no predictor and passes as is
            priority if (i_pos.first_row && i_pos.col_zero) begin
                o_pixel[k*BYTE_W +: BYTE_W] = x;
            end else if (i_pos.first_row) begin
                o_pixel[k*BYTE_W +: BYTE_W] = l - x;
            end else if (i_pos.col_zero) begin
                o_pixel[k*BYTE_W +: BYTE_W] = a - x;
            end else begin
                o_pixel[k*BYTE_W +: BYTE_W] = sum[BYTE_W:1] - x;
            end
        end
    end

endmodule
